// File: sv/rgt_pkg.sv
// ----------------------------------------------------------------------------
// rgt_pkg: shared types and constants for the RGB565 gradient tint
// Field layout, gradient constants, register indexes and the per-stage
// sideband record.
// ----------------------------------------------------------------------------
package rgt_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int EDGE_W         = 11;
  localparam int MASK_W         = 3;
  localparam int PIX_W          = 16;
  localparam int CFG_IDX_W      = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EDGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_EDGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_MASK   = 2'd2;

  localparam logic [EDGE_W-1:0] RIGHT_EDGE_RST  = 11'd320;
  localparam logic [EDGE_W-1:0] BOTTOM_EDGE_RST = 11'd240;
  localparam logic [MASK_W-1:0] TINT_MASK_RST   = 3'd6;

  // tint mask bits
  localparam int MASK_RED = 0;
  localparam int MASK_GRN = 1;
  localparam int MASK_BLU = 2;

  // RGB565 layout
  localparam logic [PIX_W-1:0] WHITE_PIX = 16'hFFFF;
  localparam logic [PIX_W-1:0] RED_FIELD = 16'hF800;
  localparam logic [PIX_W-1:0] GRN_FIELD = 16'h07E0;
  localparam logic [PIX_W-1:0] BLU_FIELD = 16'h001F;
  localparam int RED_SHIFT = 11;
  localparam int GRN_SHIFT = 5;

  // gradient constants
  localparam logic [5:0] RED_COL_K = 6'd12;
  localparam logic [5:0] RED_ROW_K = 6'd19;
  localparam logic [5:0] RED_BIAS  = 6'd19;
  localparam logic [5:0] GRN_COL_K = 6'd63;
  localparam logic [5:0] BLU_ROW_K = 6'd31;

  localparam logic [4:0] RED_MAX = 5'd31;
  localparam logic [5:0] GRN_MAX = 6'd63;
  localparam logic [4:0] BLU_MAX = 5'd31;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [MASK_W-1:0] mask;
    logic              white;
  } side_t;

endpackage

// File: sv/rgb565_gradient_tint.sv
// ----------------------------------------------------------------------------
// rgb565_gradient_tint: per-pixel gradient tint of an RGB565 stream
// Adds column/row gradient terms to the enabled channels, saturates and
// repacks; a white pixel passes through untouched.
// ----------------------------------------------------------------------------
// Usage: one pixel item per clock is accepted with its column and row while
// in_ready_o is high, and one result item comes out per pixel, in order. One
// stage forms the constant products, then a restoring divider retires one
// quotient bit per stage over COORD_BITS + 6 stages, then one stage adds,
// saturates and repacks. Throughput is one item per cycle while the output is
// not stalled; each stage has its own valid bit, so bubbles close up under
// output backpressure and the input keeps taking items until the pipe is
// truly full. Edge and mask registers may be written only while no item is
// in flight; an edge value of zero divides as one. Coordinate bits are taken
// modulo 2^COORD_BITS.
// ----------------------------------------------------------------------------
module rgb565_gradient_tint #(
  parameter int COORD_BITS = rgt_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [rgt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgt_pkg::EDGE_W-1:0]    cfg_data_i,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rgt_pkg::PIX_W-1:0]     pixel_in_i,
  input  logic [COORD_BITS-1:0]         col_i,
  input  logic [COORD_BITS-1:0]         row_i,
  // pixel output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rgt_pkg::PIX_W-1:0]     pixel_out_o
);

  // quotient width covers 63 * (2^COORD_BITS - 1)
  localparam int DW = COORD_BITS + 6;
  localparam int EW = rgt_pkg::EDGE_W;

  // ---------------- config registers ----------------
  logic [EW-1:0]                 right_q, bottom_q;
  logic [rgt_pkg::MASK_W-1:0]    mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q  <= rgt_pkg::RIGHT_EDGE_RST;
      bottom_q <= rgt_pkg::BOTTOM_EDGE_RST;
      mask_q   <= rgt_pkg::TINT_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rgt_pkg::REG_RIGHT_EDGE:  right_q  <= cfg_data_i;
        rgt_pkg::REG_BOTTOM_EDGE: bottom_q <= cfg_data_i;
        rgt_pkg::REG_TINT_MASK:   mask_q   <= cfg_data_i[rgt_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // zero edge divides as one
  logic [EW-1:0] rdiv, bdiv;
  assign rdiv = (right_q  == '0) ? EW'(1) : right_q;
  assign bdiv = (bottom_q == '0) ? EW'(1) : bottom_q;

  // ---------------- pipeline control ----------------
  // stage 0: products; stages 1..DW: divider; then the output register.
  logic [DW:0]   valid_q;
  logic [DW+1:0] rdy;
  logic          out_valid_q;

  assign rdy[DW+1] = !out_valid_q || out_ready_i;
  for (genvar k = 0; k <= DW; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k <= DW; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
      if (rdy[DW+1]) out_valid_q <= valid_q[DW];
    end
  end

  // ---------------- stage 0: constant products ----------------
  rgt_pkg::side_t side_q [DW+1];
  logic [DW-1:0]  p_rc_q, p_rr_q, p_gc_q, p_br_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p_rc_q <= DW'(col_i) * DW'(rgt_pkg::RED_COL_K);
      p_rr_q <= DW'(row_i) * DW'(rgt_pkg::RED_ROW_K);
      p_gc_q <= DW'(col_i) * DW'(rgt_pkg::GRN_COL_K);
      p_br_q <= DW'(row_i) * DW'(rgt_pkg::BLU_ROW_K);
      side_q[0].pixel <= pixel_in_i;
      side_q[0].mask  <= mask_q;
      side_q[0].white <= (pixel_in_i == rgt_pkg::WHITE_PIX);
    end
    for (int k = 1; k <= DW; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------- stages 1..DW: dividers ----------------
  logic [DW-1:0] q_rc, q_rr, q_gc, q_br;

  rgt_divider #(.DIV_BITS(DW), .VSOR_BITS(EW)) u_div_rc (
    .clk_i, .en_i(rdy[DW:1]), .dividend_i(p_rc_q), .divisor_i(rdiv), .quotient_o(q_rc)
  );
  rgt_divider #(.DIV_BITS(DW), .VSOR_BITS(EW)) u_div_rr (
    .clk_i, .en_i(rdy[DW:1]), .dividend_i(p_rr_q), .divisor_i(bdiv), .quotient_o(q_rr)
  );
  rgt_divider #(.DIV_BITS(DW), .VSOR_BITS(EW)) u_div_gc (
    .clk_i, .en_i(rdy[DW:1]), .dividend_i(p_gc_q), .divisor_i(rdiv), .quotient_o(q_gc)
  );
  rgt_divider #(.DIV_BITS(DW), .VSOR_BITS(EW)) u_div_br (
    .clk_i, .en_i(rdy[DW:1]), .dividend_i(p_br_q), .divisor_i(bdiv), .quotient_o(q_br)
  );

  // ---------------- output stage: add, saturate, repack ----------------
  rgt_pkg::side_t          last;
  logic [DW:0]             red_plus, red_diff;
  logic [DW+1:0]           r_sum, g_sum, b_sum;
  logic [4:0]              r_o, b_o;
  logic [5:0]              g_o;
  logic [rgt_pkg::PIX_W-1:0] pix_d;
  logic [rgt_pkg::PIX_W-1:0] pixel_out_q;

  assign last = side_q[DW];

  always_comb begin
    red_plus = {1'b0, q_rc} + (DW+1)'(rgt_pkg::RED_BIAS);
    red_diff = red_plus - {1'b0, q_rr};
    r_sum = (DW+2)'((last.pixel & rgt_pkg::RED_FIELD) >> rgt_pkg::RED_SHIFT);
    g_sum = (DW+2)'((last.pixel & rgt_pkg::GRN_FIELD) >> rgt_pkg::GRN_SHIFT);
    b_sum = (DW+2)'(last.pixel & rgt_pkg::BLU_FIELD);
    // red term floors at zero: only added when the bias side wins
    if (last.mask[rgt_pkg::MASK_RED] && (red_plus > {1'b0, q_rr})) begin
      r_sum = r_sum + {1'b0, red_diff};
    end
    if (last.mask[rgt_pkg::MASK_GRN]) g_sum = g_sum + {2'b00, q_gc};
    if (last.mask[rgt_pkg::MASK_BLU]) b_sum = b_sum + {2'b00, q_br};
    r_o = (r_sum > (DW+2)'(rgt_pkg::RED_MAX)) ? rgt_pkg::RED_MAX : r_sum[4:0];
    g_o = (g_sum > (DW+2)'(rgt_pkg::GRN_MAX)) ? rgt_pkg::GRN_MAX : g_sum[5:0];
    b_o = (b_sum > (DW+2)'(rgt_pkg::BLU_MAX)) ? rgt_pkg::BLU_MAX : b_sum[4:0];
    pix_d = last.white ? last.pixel : {r_o, g_o, b_o};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[DW+1]) pixel_out_q <= pix_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;

endmodule

// File: sv/rgt_divider.sv
// ----------------------------------------------------------------------------
// rgt_divider: pipelined restoring divider
// One quotient bit per stage, DIV_BITS stages. Each stage loads when its
// enable bit is high. The divisor must hold steady while items are in flight.
// ----------------------------------------------------------------------------
module rgt_divider #(
  parameter int DIV_BITS  = rgt_pkg::COORD_BITS_DEF + 6,
  parameter int VSOR_BITS = rgt_pkg::EDGE_W
) (
  input  logic                 clk_i,
  input  logic [DIV_BITS-1:0]  en_i,
  input  logic [DIV_BITS-1:0]  dividend_i,
  input  logic [VSOR_BITS-1:0] divisor_i,
  output logic [DIV_BITS-1:0]  quotient_o
);

  // dq holds the unconsumed dividend bits on top, quotient bits shifting in below
  logic [VSOR_BITS-1:0] rem_q [DIV_BITS];
  logic [DIV_BITS-1:0]  dq_q  [DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
    logic [VSOR_BITS-1:0] rem_in;
    logic [DIV_BITS-1:0]  dq_in;
    logic [VSOR_BITS:0]   trial;
    logic [VSOR_BITS:0]   diff;
    logic                 ge;
    logic [VSOR_BITS-1:0] rem_d;
    logic [DIV_BITS-1:0]  dq_d;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dq_in  = dq_q[j-1];
    end

    assign trial = {rem_in, dq_in[DIV_BITS-1]};
    assign diff  = trial - {1'b0, divisor_i};
    assign ge    = (trial >= {1'b0, divisor_i});
    assign rem_d = ge ? diff[VSOR_BITS-1:0] : trial[VSOR_BITS-1:0];
    assign dq_d  = {dq_in[DIV_BITS-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d;
        dq_q[j]  <= dq_d;
      end
    end
  end

  assign quotient_o = dq_q[DIV_BITS-1];

endmodule
